// ===== rtl/core/fixed_block_free_list_allocator_defines.svh =====
// Assertion macros for the fixed-size block free-list allocator.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Checked only while out of reset.
`define FBFLA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FBFLA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fbfla_pkg.sv =====
// Shared types and constants of the fixed-size block free-list allocator.
`default_nettype none

package fbfla_pkg;

    localparam int BLOCK_COUNT = 1024;
    // power of two: address to index is a shift
    localparam int BLOCK_BYTES = 4096;
    localparam int BYTE_SHIFT  = $clog2(BLOCK_BYTES);
    localparam int IDX_W       = $clog2(BLOCK_COUNT);
    localparam int LINK_W      = $clog2(BLOCK_COUNT + 1);
    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 32;
    localparam int GRANT_IDX_W = 10;
    localparam int STATUS_W    = 2;

    localparam logic [LINK_W-1:0] EMPTY_CODE = LINK_W'(BLOCK_COUNT);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_BIG = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd3;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_ALLOC_BIG,
        CMD_FREE,
        CMD_FREE_BAD
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ
    } back_state_t;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] release_address;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ADDR_W-1:0]      grant_address;
        logic [GRANT_IDX_W-1:0] grant_index;
    } result_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] blk;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/fbfla_front.sv =====
// Front end: decodes a request and maps a release address to a block index.
`default_nettype none

module fbfla_front (
    input  fbfla_pkg::request_t           request,
    input  logic [fbfla_pkg::ADDR_W-1:0]  pool_base,
    output fbfla_pkg::cmd_t               cmd
);

    logic [fbfla_pkg::ADDR_W-1:0] offset;
    logic [fbfla_pkg::ADDR_W-1:0] blk_wide;
    logic                         too_big;
    logic                         outside;

    assign offset   = request.release_address - pool_base;
    assign blk_wide = offset >> fbfla_pkg::BYTE_SHIFT;
    assign too_big  = request.request_size > fbfla_pkg::SIZE_W'(fbfla_pkg::BLOCK_BYTES);
    assign outside  = blk_wide >= fbfla_pkg::ADDR_W'(fbfla_pkg::BLOCK_COUNT);

    always_comb
    begin
        cmd.blk = blk_wide[fbfla_pkg::IDX_W-1:0];
        if (request.func == fbfla_pkg::FUNC_FREE)
        begin
            cmd.kind = outside ? fbfla_pkg::CMD_FREE_BAD : fbfla_pkg::CMD_FREE;
        end
        else
        begin
            cmd.kind = too_big ? fbfla_pkg::CMD_ALLOC_BIG : fbfla_pkg::CMD_ALLOC;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fbfla_cmd_queue.sv =====
// Two-entry queue of decoded commands between front end and back end.
`default_nettype none

module fbfla_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fbfla_pkg::cmd_t cmd_in,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output fbfla_pkg::cmd_t cmd_out
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fbfla_pkg::cmd_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign valid   = count_reg != '0;
    assign cmd_out = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fbfla_back.sv =====
// Back end: free-list table, head index, init sweep and result queue.
`default_nettype none

module fbfla_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  fbfla_pkg::cmd_t              cmd,
    output logic                         cmd_pop,
    input  logic [fbfla_pkg::ADDR_W-1:0] pool_base,
    output logic                         init_busy,
    output logic                         empty,
    input  logic                         pop,
    output fbfla_pkg::result_t           result
);

    localparam int IDX_W   = fbfla_pkg::IDX_W;
    localparam int LINK_W  = fbfla_pkg::LINK_W;
    localparam int R_DEPTH = 2;
    localparam int R_PTR_W = $clog2(R_DEPTH);
    localparam int R_CNT_W = $clog2(R_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(fbfla_pkg::BLOCK_COUNT - 1);

    fbfla_pkg::back_state_t state_reg, state_next;

    logic [LINK_W-1:0] mem [fbfla_pkg::BLOCK_COUNT];
    logic [LINK_W-1:0] rdata_reg;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0]  init_cnt_reg, init_cnt_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;

    fbfla_pkg::result_t res_entry_reg [R_DEPTH];
    logic [R_PTR_W-1:0] res_wr_reg, res_wr_next;
    logic [R_PTR_W-1:0] res_rd_reg, res_rd_next;
    logic [R_CNT_W-1:0] res_count_reg, res_count_next;
    logic               res_full;
    logic               res_push;
    logic               res_pop;
    fbfla_pkg::result_t res_data;

    logic               head_empty;
    logic               take;

    assign head_empty = head_reg == fbfla_pkg::EMPTY_CODE;
    assign res_full   = res_count_reg == R_CNT_W'(R_DEPTH);
    assign take       = cmd_valid && !res_full;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbfla_pkg::ST_INIT:
            begin
                if (init_cnt_reg == LAST_IDX)
                begin
                    state_next = fbfla_pkg::ST_IDLE;
                end
            end
            fbfla_pkg::ST_IDLE:
            begin
                if (take && cmd.kind == fbfla_pkg::CMD_ALLOC && !head_empty)
                begin
                    state_next = fbfla_pkg::ST_READ;
                end
            end
            fbfla_pkg::ST_READ:
            begin
                state_next = fbfla_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fbfla_pkg::ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        init_busy     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = init_cnt_reg;
        mem_wdata     = head_reg;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        res_data      = '0;
        head_next     = head_reg;
        init_cnt_next = init_cnt_reg;
        case (state_reg)
            fbfla_pkg::ST_INIT:
            begin
                init_busy     = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = init_cnt_reg;
                mem_wdata     = (init_cnt_reg == LAST_IDX) ? fbfla_pkg::EMPTY_CODE
                                                           : LINK_W'(init_cnt_reg) + 1'b1;
                init_cnt_next = init_cnt_reg + 1'b1;
            end
            fbfla_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        fbfla_pkg::CMD_ALLOC:
                        begin
                            if (head_empty)
                            begin
                                res_push        = 1'b1;
                                res_data.status = fbfla_pkg::STATUS_EMPTY;
                            end
                        end
                        fbfla_pkg::CMD_ALLOC_BIG:
                        begin
                            res_push        = 1'b1;
                            res_data.status = head_empty ? fbfla_pkg::STATUS_EMPTY
                                                         : fbfla_pkg::STATUS_TOO_BIG;
                        end
                        fbfla_pkg::CMD_FREE:
                        begin
                            mem_we               = 1'b1;
                            mem_waddr            = cmd.blk;
                            mem_wdata            = head_reg;
                            head_next            = LINK_W'(cmd.blk);
                            res_push             = 1'b1;
                            res_data.status      = fbfla_pkg::STATUS_OK;
                            res_data.grant_index = fbfla_pkg::GRANT_IDX_W'(cmd.blk);
                        end
                        default:
                        begin
                            res_push        = 1'b1;
                            res_data.status = fbfla_pkg::STATUS_OUTSIDE;
                        end
                    endcase
                end
            end
            fbfla_pkg::ST_READ:
            begin
                head_next              = rdata_reg;
                res_push               = 1'b1;
                res_data.status        = fbfla_pkg::STATUS_OK;
                res_data.grant_address = pool_base
                    + (fbfla_pkg::ADDR_W'(head_reg[IDX_W-1:0]) << fbfla_pkg::BYTE_SHIFT);
                res_data.grant_index   = fbfla_pkg::GRANT_IDX_W'(head_reg[IDX_W-1:0]);
            end
            default:
            begin
                init_busy = 1'b1;
            end
        endcase
    end

    // result queue
    assign res_pop = pop && !empty;
    assign empty   = res_count_reg == '0;
    assign result  = res_entry_reg[res_rd_reg];

    always_comb
    begin
        res_wr_next    = res_push ? res_wr_reg + 1'b1 : res_wr_reg;
        res_rd_next    = res_pop ? res_rd_reg + 1'b1 : res_rd_reg;
        res_count_next = res_count_reg + R_CNT_W'(res_push) - R_CNT_W'(res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbfla_pkg::ST_INIT;
            head_reg      <= '0;
            init_cnt_reg  <= '0;
            res_wr_reg    <= '0;
            res_rd_reg    <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            init_cnt_reg  <= init_cnt_next;
            res_wr_reg    <= res_wr_next;
            res_rd_reg    <= res_rd_next;
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[head_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_entry_reg[res_wr_reg] <= res_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fixed_block_free_list_allocator.sv =====
// Top level of the fixed-size block free-list allocator.
// Usage:
//   Requests enter through a queue-style port: a transfer happens when push is
//   high and full is low. func selects allocate or free.
//   Results leave through a queue-style port: the oldest result sits on result
//   while empty is low and is transferred when pop is high.
//   pool_base is set through cfg_write/cfg_data; write it only while idle.
// Timing:
//   A result for a free or a failed allocate passes the command queue and then
//   the result queue; a granted allocate also passes the next-index table read.
//   Frees and failures sustain one per cycle while the result queue has room;
//   a granted allocate holds the back end in its read state, for the registered
//   read of the next-index table, before the head can move and a new one is taken.
// Reset:
//   Clears both queues and the head, then sweeps the next-index table, one
//   entry a cycle, all 1024 entries with full held high.
// Stall:
//   Two results and two requests can wait; full rises once the command queue fills.
`default_nettype none

module fixed_block_free_list_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  fbfla_pkg::request_t          request,
    output logic                         empty,
    input  logic                         pop,
    output fbfla_pkg::result_t           result,
    input  logic                         cfg_write,
    input  logic [fbfla_pkg::ADDR_W-1:0] cfg_data
);

    logic [fbfla_pkg::ADDR_W-1:0] pool_base_reg;
    fbfla_pkg::cmd_t              front_cmd;
    fbfla_pkg::cmd_t              queue_cmd;
    logic                         queue_full;
    logic                         queue_valid;
    logic                         queue_pop;
    logic                         init_busy;

    assign full = queue_full || init_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
        end
        else if (cfg_write)
        begin
            pool_base_reg <= cfg_data;
        end
    end

    fbfla_front u_front (
        .request   (request),
        .pool_base (pool_base_reg),
        .cmd       (front_cmd)
    );

    fbfla_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push && !init_busy),
        .cmd_in  (front_cmd),
        .full    (queue_full),
        .pop     (queue_pop),
        .valid   (queue_valid),
        .cmd_out (queue_cmd)
    );

    fbfla_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .pool_base (pool_base_reg),
        .init_busy (init_busy),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/fbfla_checker.sv =====
// Port-level checks of the allocator, bound to the top level.
`default_nettype none

`include "fixed_block_free_list_allocator_defines.svh"

module fbfla_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input fbfla_pkg::result_t result
);

    `FBFLA_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> empty, "results present during reset")

    `FBFLA_ASSERT_ALWAYS(a_init_full, $past(!rst_n) && rst_n |-> full, "input open during table sweep")

    `FBFLA_ASSERT(a_result_hold, !empty && !pop |=> !empty && $stable(result), "waiting result moved")

    `FBFLA_ASSERT(a_fail_zero, !empty && result.status != fbfla_pkg::STATUS_OK |-> result.grant_address == '0 && result.grant_index == '0, "failed result carries an address or index")

endmodule

bind fixed_block_free_list_allocator fbfla_checker u_checker (.*);

`default_nettype wire
